>>> rtl/pd_position_drive_controller_defines.svh
// ----------------------------------------------------------------------------
// pd_position_drive_controller_defines
// assertion macros used by the drive controller checker
// ----------------------------------------------------------------------------
`ifndef PD_POSITION_DRIVE_CONTROLLER_DEFINES_SVH
`define PD_POSITION_DRIVE_CONTROLLER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define PDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// pdc_pkg
// widths, register codes, modes and reset values of the pd drive controller
// ----------------------------------------------------------------------------
package pdc_pkg;

  // encoder position and gain formats
  localparam int POSITION_BITS      = 24;
  localparam int GAIN_FRACTION_BITS = 8;
  localparam int GAIN_W             = 16;

  // datapath widths
  localparam int ERR_W  = POSITION_BITS + 1;
  localparam int DIFF_W = POSITION_BITS + 2;
  localparam int SUM_W  = DIFF_W + GAIN_W + 2;

  // drive command format
  localparam int DRV_W = 8;
  localparam int CAP_W = 7;
  localparam logic [CAP_W-1:0] DRIVE_MAX = 7'd127;

  // step counter
  localparam int STEP_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (POSITION_BITS > GAIN_W) ? POSITION_BITS : GAIN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE,
    CFG_REVERSE,
    CFG_TARGET,
    CFG_TIMEOUT,
    CFG_CAP,
    CFG_PROP_GAIN,
    CFG_DERIV_GAIN
  } cfg_reg_e;

  // wheel sign patterns; the unused code drives like a straight move
  typedef enum logic [1:0] {
    MODE_MOVE,
    MODE_TURN,
    MODE_STRAFE
  } drive_mode_e;

  // register reset values
  localparam logic [STEP_W-1:0] TIMEOUT_RST    = 16'd250;
  localparam logic [CAP_W-1:0]  CAP_RST        = 7'd127;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd179;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd282;

endpackage

>>> rtl/pd_position_drive_controller.sv
// ----------------------------------------------------------------------------
// pd_position_drive_controller
// pd position loop with power clamp and four-wheel drive sign patterns
// ----------------------------------------------------------------------------
// Takes one encoder sample per clock cycle while the drive channel does not
// stall, and returns one set of four drive commands per sample, in order. A
// sample is held in the input register, the pd multiply-add, truncation, clamp
// and wheel signing run in a single combinational pass, and the result lands
// in the output register. Throughput is one sample per cycle, set by that
// single multiply-add pass, while out_ready_i does not hold the output register.
// The error history, step count and held power update as a sample moves into
// the output register, so the next sample sees them at once. Configuration is
// written through a plain write port and must only change while the block
// holds no sample.
module pd_position_drive_controller (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write port
  input  logic                                   cfg_we_i,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  // sample channel
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   start_req_i,
  input  logic signed [pdc_pkg::POSITION_BITS-1:0] left_position_i,
  input  logic signed [pdc_pkg::POSITION_BITS-1:0] right_position_i,
  // drive channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [pdc_pkg::DRV_W-1:0]       left_back_drive_o,
  output logic signed [pdc_pkg::DRV_W-1:0]       left_front_drive_o,
  output logic signed [pdc_pkg::DRV_W-1:0]       right_back_drive_o,
  output logic signed [pdc_pkg::DRV_W-1:0]       right_front_drive_o,
  output logic                                   expired_o
);

  // configuration registers
  logic [1:0]                                mode_q;
  logic                                      reverse_q;
  logic signed [pdc_pkg::POSITION_BITS-1:0]  target_q;
  logic [pdc_pkg::STEP_W-1:0]                timeout_q;
  logic [pdc_pkg::CAP_W-1:0]                 cap_q;
  logic [pdc_pkg::GAIN_W-1:0]                prop_gain_q;
  logic [pdc_pkg::GAIN_W-1:0]                deriv_gain_q;

  // input register
  logic                                      s1_valid_q;
  logic                                      s1_start_q;
  logic signed [pdc_pkg::POSITION_BITS-1:0]  s1_left_q;
  logic signed [pdc_pkg::POSITION_BITS-1:0]  s1_right_q;

  // loop state
  logic signed [pdc_pkg::ERR_W-1:0]          prev_err_q, prev_err_d;
  logic [pdc_pkg::STEP_W-1:0]                step_cnt_q, step_cnt_d;
  logic signed [pdc_pkg::DRV_W-1:0]          held_pwr_q, held_pwr_d;

  // output register
  logic                                      out_valid_q;
  logic signed [pdc_pkg::DRV_W-1:0]          lb_q, lf_q, rb_q, rf_q;
  logic signed [pdc_pkg::DRV_W-1:0]          lb_d, lf_d, rb_d, rf_d;
  logic                                      expired_q, expired_d;

  // handshake
  logic in_accept;
  logic out_free;
  logic s1_adv;

  // datapath
  logic                                      is_turn;
  logic signed [pdc_pkg::POSITION_BITS-1:0]  pos_sel;
  logic signed [pdc_pkg::ERR_W-1:0]          pos_ext;
  logic signed [pdc_pkg::ERR_W-1:0]          pos_mag;
  logic signed [pdc_pkg::ERR_W-1:0]          target_ext;
  logic signed [pdc_pkg::ERR_W-1:0]          err;
  logic signed [pdc_pkg::ERR_W-1:0]          prev_eff;
  logic [pdc_pkg::STEP_W-1:0]                cnt_eff;
  logic signed [pdc_pkg::DIFF_W-1:0]         diff;
  logic signed [pdc_pkg::GAIN_W:0]           prop_gain_s;
  logic signed [pdc_pkg::GAIN_W:0]           deriv_gain_s;
  logic signed [pdc_pkg::ERR_W+pdc_pkg::GAIN_W:0]  prop_prod;
  logic signed [pdc_pkg::DIFF_W+pdc_pkg::GAIN_W:0] deriv_prod;
  logic signed [pdc_pkg::SUM_W-1:0]          sum;
  logic signed [pdc_pkg::SUM_W-1:0]          quot;
  logic                                      round_up;
  logic signed [pdc_pkg::SUM_W-1:0]          pwr_full;
  logic [pdc_pkg::CAP_W-1:0]                 lim;
  logic signed [pdc_pkg::SUM_W-1:0]          lim_pos;
  logic signed [pdc_pkg::SUM_W-1:0]          lim_neg;
  logic signed [pdc_pkg::DRV_W-1:0]          pwr_new;
  logic                                      expired_now;
  logic signed [pdc_pkg::DRV_W-1:0]          pwr_base;
  logic signed [pdc_pkg::DRV_W-1:0]          pwr_signed;

  // pipeline control
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= pdc_pkg::MODE_MOVE;
      reverse_q    <= 1'b0;
      target_q     <= '0;
      timeout_q    <= pdc_pkg::TIMEOUT_RST;
      cap_q        <= pdc_pkg::CAP_RST;
      prop_gain_q  <= pdc_pkg::PROP_GAIN_RST;
      deriv_gain_q <= pdc_pkg::DERIV_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pdc_pkg::CFG_MODE:       mode_q       <= cfg_data_i[1:0];
        pdc_pkg::CFG_REVERSE:    reverse_q    <= cfg_data_i[0];
        pdc_pkg::CFG_TARGET:     target_q     <= cfg_data_i[pdc_pkg::POSITION_BITS-1:0];
        pdc_pkg::CFG_TIMEOUT:    timeout_q    <= cfg_data_i[pdc_pkg::STEP_W-1:0];
        pdc_pkg::CFG_CAP:        cap_q        <= cfg_data_i[pdc_pkg::CAP_W-1:0];
        pdc_pkg::CFG_PROP_GAIN:  prop_gain_q  <= cfg_data_i[pdc_pkg::GAIN_W-1:0];
        pdc_pkg::CFG_DERIV_GAIN: deriv_gain_q <= cfg_data_i[pdc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_start_q <= start_req_i;
      s1_left_q  <= left_position_i;
      s1_right_q <= right_position_i;
    end
  end

  // start clears the history before this sample is used
  assign prev_eff    = s1_start_q ? '0 : prev_err_q;
  assign cnt_eff     = s1_start_q ? '0 : step_cnt_q;
  assign expired_now = (cnt_eff >= timeout_q);

  // error: turn mode uses the magnitude of the chosen encoder
  assign is_turn    = (mode_q == pdc_pkg::MODE_TURN);
  assign pos_sel    = (is_turn && reverse_q) ? s1_right_q : s1_left_q;
  assign pos_ext    = {pos_sel[pdc_pkg::POSITION_BITS-1], pos_sel};
  assign pos_mag    = (is_turn && pos_ext[pdc_pkg::ERR_W-1]) ? -pos_ext : pos_ext;
  assign target_ext = {target_q[pdc_pkg::POSITION_BITS-1], target_q};
  assign err        = target_ext - pos_mag;
  assign diff       = {err[pdc_pkg::ERR_W-1], err} - {prev_eff[pdc_pkg::ERR_W-1], prev_eff};

  // pd multiply-add in q8.8
  assign prop_gain_s  = {1'b0, prop_gain_q};
  assign deriv_gain_s = {1'b0, deriv_gain_q};
  assign prop_prod    = err * prop_gain_s;
  assign deriv_prod   = diff * deriv_gain_s;
  assign sum          = pdc_pkg::SUM_W'(prop_prod) + pdc_pkg::SUM_W'(deriv_prod);

  // drop the fraction, rounding toward zero
  assign quot     = sum >>> pdc_pkg::GAIN_FRACTION_BITS;
  assign round_up = sum[pdc_pkg::SUM_W-1] && (|sum[pdc_pkg::GAIN_FRACTION_BITS-1:0]);
  assign pwr_full = quot + {{(pdc_pkg::SUM_W-1){1'b0}}, round_up};

  // clamp to cap outside turn mode, never beyond full scale
  assign lim     = is_turn ? pdc_pkg::DRIVE_MAX : cap_q;
  assign lim_pos = {{(pdc_pkg::SUM_W-pdc_pkg::CAP_W){1'b0}}, lim};
  assign lim_neg = -lim_pos;

  always_comb begin
    if (pwr_full > lim_pos) begin
      pwr_new = pdc_pkg::DRV_W'(lim_pos);
    end else if (pwr_full < lim_neg) begin
      pwr_new = pdc_pkg::DRV_W'(lim_neg);
    end else begin
      pwr_new = pdc_pkg::DRV_W'(pwr_full);
    end
  end

  // wheel sign pattern
  assign pwr_base   = expired_now ? held_pwr_q : pwr_new;
  assign pwr_signed = reverse_q ? -pwr_base : pwr_base;

  always_comb begin
    unique case (mode_q)
      pdc_pkg::MODE_TURN: begin
        lb_d = -pwr_signed;
        lf_d = -pwr_signed;
        rb_d = pwr_signed;
        rf_d = pwr_signed;
      end
      pdc_pkg::MODE_STRAFE: begin
        lb_d = -pwr_signed;
        lf_d = pwr_signed;
        rb_d = pwr_signed;
        rf_d = -pwr_signed;
      end
      default: begin
        lb_d = pwr_signed;
        lf_d = pwr_signed;
        rb_d = pwr_signed;
        rf_d = pwr_signed;
      end
    endcase
  end
  assign expired_d = expired_now;

  // next loop state: an expired sample only applies the start clear
  always_comb begin
    if (expired_now) begin
      prev_err_d = prev_eff;
      step_cnt_d = cnt_eff;
      held_pwr_d = held_pwr_q;
    end else begin
      prev_err_d = err;
      step_cnt_d = cnt_eff + 1'b1;
      held_pwr_d = pwr_new;
    end
  end

  // loop state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      step_cnt_q <= '0;
      held_pwr_q <= '0;
    end else if (s1_adv) begin
      prev_err_q <= prev_err_d;
      step_cnt_q <= step_cnt_d;
      held_pwr_q <= held_pwr_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      lb_q      <= lb_d;
      lf_q      <= lf_d;
      rb_q      <= rb_d;
      rf_q      <= rf_d;
      expired_q <= expired_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign left_back_drive_o   = lb_q;
  assign left_front_drive_o  = lf_q;
  assign right_back_drive_o  = rb_q;
  assign right_front_drive_o = rf_q;
  assign expired_o           = expired_q;

endmodule

>>> rtl/pdc_checker.sv
// ----------------------------------------------------------------------------
// pdc_checker
// port-level checks of the pd drive controller, bound to the top level
// ----------------------------------------------------------------------------
`include "pd_position_drive_controller_defines.svh"

module pdc_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_ready_o,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic signed [pdc_pkg::DRV_W-1:0]       left_back_drive_o,
  input logic signed [pdc_pkg::DRV_W-1:0]       left_front_drive_o,
  input logic signed [pdc_pkg::DRV_W-1:0]       right_back_drive_o,
  input logic signed [pdc_pkg::DRV_W-1:0]       right_front_drive_o,
  input logic                                   expired_o
);

  // a stalled result stays put
  `PDC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(left_back_drive_o) && $stable(left_front_drive_o) && $stable(right_back_drive_o) && $stable(right_front_drive_o) && $stable(expired_o), "drive result changed while stalled")

  // back-pressure on the input only when a result is waiting
  `PDC_ASSERT_NOW(a_ready_backpressure, !in_ready_o, out_valid_o, "input stalled with no result pending")

  // drive commands never reach the most negative code
  `PDC_ASSERT_NOW(a_drive_range, out_valid_o, (left_back_drive_o != -8'sd128) && (left_front_drive_o != -8'sd128) && (right_back_drive_o != -8'sd128) && (right_front_drive_o != -8'sd128), "drive command out of range")

  // every pattern gives all four wheels the same magnitude
  `PDC_ASSERT_NOW(a_wheel_pattern, out_valid_o, ((left_back_drive_o == right_back_drive_o) || (left_back_drive_o == -right_back_drive_o)) && ((left_front_drive_o == right_front_drive_o) || (left_front_drive_o == -right_front_drive_o)) && ((left_back_drive_o == left_front_drive_o) || (left_back_drive_o == -left_front_drive_o)), "wheel commands differ in magnitude")

endmodule

bind pd_position_drive_controller pdc_checker u_pdc_checker (.*);
